// ===== design/nvd_pkg.sv =====
package nvd_pkg;

    localparam int NAME_MAX_LEN_DEF = 1024;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_ALLOW_ONE_LEVEL  = 2'd0;
    localparam logic [1:0] CFG_PATTERN_MODE     = 2'd1;
    localparam logic [1:0] CFG_COLLAPSE_SLASHES = 2'd2;
    localparam logic [1:0] CFG_MAX_LENGTH       = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Result kinds and status codes
    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // ".lock" as the last five bytes of a segment
    localparam logic [39:0] LOCK_TAIL = 40'h2E6C6F636B;

    // Segment length is only compared against zero and five
    localparam int SEG_LEN_W = 3;
    localparam logic [SEG_LEN_W-1:0] SEG_LEN_SAT = 3'd5;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic                  allow_one_level;
        logic                  pattern_mode;
        logic                  collapse_slashes;
        logic [CFG_DATA_W-1:0] max_length;
    } t_cfg;

    // One queued transaction: a byte (optionally preceded by '/') or a status
    typedef struct packed {
        logic       kind;
        logic       slash;
        logic [7:0] byte_val;
        logic [1:0] status;
    } t_entry;

    function automatic logic forbidden_byte(input logic [7:0] b);
        return (b <= CH_SPACE) || (b == CH_DEL) || (b == CH_TILDE) ||
               (b == CH_CARET) || (b == CH_COLON) || (b == CH_BSLASH) ||
               (b == CH_QUEST) || (b == CH_LBRACK) || (b == CH_STAR);
    endfunction

    function automatic logic caps_or_underscore(input logic [7:0] b);
        return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) || (b == CH_UNDER);
    endfunction

endpackage

// ===== design/nvd_fifo.sv =====
module nvd_fifo
    import nvd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_data
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_entry         r_mem [FIFO_DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/nvd_front.sv =====
module nvd_front
    import nvd_pkg::*;
#(
    parameter int NAME_MAX_LEN = NAME_MAX_LEN_DEF
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_name_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_entry     o_entry
);

    localparam int LW = $clog2(NAME_MAX_LEN + 1);
    localparam int CW = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;

    logic                 r_at_start,   n_at_start;
    logic                 r_pending,    n_pending;
    logic [SEG_LEN_W-1:0] r_seg_len,    n_seg_len;
    logic [7:0]           r_prev,       n_prev;
    logic [39:0]          r_tail,       n_tail;
    logic [1:0]           r_seg_count,  n_seg_count;
    logic                 r_first_caps, n_first_caps;
    logic                 r_seg_caps,   n_seg_caps;
    logic                 r_seg_us,     n_seg_us;
    logic                 r_seg_bad,    n_seg_bad;
    logic                 r_seg_star,   n_seg_star;
    logic                 r_wild,       n_wild;
    logic [LW-1:0]        r_out_len,    n_out_len;
    logic                 r_err,        n_err;

    logic accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        logic          seg_empty;
        logic          c_err;
        logic          c_wild;
        logic          c_first_caps;
        logic [1:0]    c_count;
        logic          z_err;
        logic [CW-1:0] limit;
        logic [LW:0]   len_sum;
        logic [7:0]    b;

        b = i_name_byte;

        n_at_start   = r_at_start;
        n_pending    = r_pending;
        n_seg_len    = r_seg_len;
        n_prev       = r_prev;
        n_tail       = r_tail;
        n_seg_count  = r_seg_count;
        n_first_caps = r_first_caps;
        n_seg_caps   = r_seg_caps;
        n_seg_us     = r_seg_us;
        n_seg_bad    = r_seg_bad;
        n_seg_star   = r_seg_star;
        n_wild       = r_wild;
        n_out_len    = r_out_len;
        n_err        = r_err;

        o_push  = 1'b0;
        o_entry = '{kind: KIND_BYTE, slash: 1'b0, byte_val: b, status: ST_VALID};

        // Judge the segment that closes on a separator or terminator
        seg_empty    = (r_seg_len == '0);
        c_err        = r_err;
        c_wild       = r_wild;
        c_first_caps = r_first_caps;
        c_count      = r_seg_count;
        if (seg_empty) begin
            if (!i_cfg.collapse_slashes) begin
                c_err = 1'b1;
            end
        end else begin
            if (r_seg_bad || ((r_seg_len >= SEG_LEN_SAT) && (r_tail == LOCK_TAIL))) begin
                if (i_cfg.pattern_mode && !r_wild && r_seg_star) begin
                    c_wild = 1'b1;
                end else begin
                    c_err = 1'b1;
                end
            end
            if (r_seg_count == 2'd0) begin
                c_first_caps = r_seg_caps && !r_seg_us && (r_prev != CH_UNDER);
            end
            if (r_seg_count < 2'd2) begin
                c_count = r_seg_count + 2'd1;
            end
        end

        limit = (CW'(i_cfg.max_length) > CW'(NAME_MAX_LEN - 1)) ?
                CW'(NAME_MAX_LEN - 1) : CW'(i_cfg.max_length);
        len_sum = {1'b0, r_out_len} + (r_pending ? (LW+1)'(2) : (LW+1)'(1));

        z_err = c_err || seg_empty || (r_prev == CH_DOT);
        if (c_count == 2'd1) begin
            if (!i_cfg.allow_one_level) begin
                z_err = 1'b1;
            end else if (!(c_first_caps || (i_cfg.pattern_mode && r_seg_star))) begin
                z_err = 1'b1;
            end
        end else if ((c_count == 2'd2) && c_first_caps) begin
            z_err = 1'b1;
        end

        if (accept) begin
            priority if (b == CH_NUL) begin
                o_push = 1'b1;
                o_entry.kind     = KIND_STATUS;
                o_entry.byte_val = 8'h00;
                if (z_err) begin
                    o_entry.status = ST_INVALID;
                end else if (i_cfg.collapse_slashes && (CW'(r_out_len) > limit)) begin
                    o_entry.status = ST_TOO_LONG;
                end else begin
                    o_entry.status = ST_VALID;
                end
                // start over for the next name
                n_at_start   = 1'b1;
                n_pending    = 1'b0;
                n_seg_count  = 2'd0;
                n_first_caps = 1'b1;
                n_wild       = 1'b0;
                n_out_len    = '0;
                n_err        = 1'b0;
                n_seg_len    = '0;
                n_prev       = 8'h00;
                n_tail       = '0;
                n_seg_caps   = 1'b1;
                n_seg_us     = 1'b0;
                n_seg_bad    = 1'b0;
                n_seg_star   = 1'b0;
            end else if (b == CH_SLASH) begin
                n_err        = c_err || r_at_start;
                n_at_start   = 1'b0;
                n_wild       = c_wild;
                n_first_caps = c_first_caps;
                n_seg_count  = c_count;
                n_pending    = r_pending || (c_count != 2'd0);
                n_seg_len    = '0;
                n_prev       = 8'h00;
                n_tail       = '0;
                n_seg_caps   = 1'b1;
                n_seg_us     = 1'b0;
                n_seg_bad    = 1'b0;
                n_seg_star   = 1'b0;
            end else begin
                n_at_start = 1'b0;
                if (seg_empty) begin
                    if (b == CH_DOT) begin
                        n_seg_bad = 1'b1;
                    end
                    n_seg_us   = (b == CH_UNDER);
                    n_seg_star = (b == CH_STAR);
                end else begin
                    n_seg_star = 1'b0;
                end
                if (forbidden_byte(b) ||
                    ((r_prev == CH_DOT) && (b == CH_DOT)) ||
                    ((r_prev == CH_AT) && (b == CH_LBRACE))) begin
                    n_seg_bad = 1'b1;
                end
                if (!caps_or_underscore(b)) begin
                    n_seg_caps = 1'b0;
                end
                if (r_seg_len < SEG_LEN_SAT) begin
                    n_seg_len = r_seg_len + 1'b1;
                end
                n_tail = {r_tail[31:0], b};
                n_prev = b;

                o_push        = 1'b1;
                o_entry.slash = r_pending;
                n_pending     = 1'b0;
                n_out_len = (len_sum > (LW+1)'(NAME_MAX_LEN)) ?
                            LW'(NAME_MAX_LEN) : len_sum[LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_pending    <= 1'b0;
            r_seg_len    <= '0;
            r_prev       <= 8'h00;
            r_tail       <= '0;
            r_seg_count  <= 2'd0;
            r_first_caps <= 1'b1;
            r_seg_caps   <= 1'b1;
            r_seg_us     <= 1'b0;
            r_seg_bad    <= 1'b0;
            r_seg_star   <= 1'b0;
            r_wild       <= 1'b0;
            r_out_len    <= '0;
            r_err        <= 1'b0;
        end else begin
            r_at_start   <= n_at_start;
            r_pending    <= n_pending;
            r_seg_len    <= n_seg_len;
            r_prev       <= n_prev;
            r_tail       <= n_tail;
            r_seg_count  <= n_seg_count;
            r_first_caps <= n_first_caps;
            r_seg_caps   <= n_seg_caps;
            r_seg_us     <= n_seg_us;
            r_seg_bad    <= n_seg_bad;
            r_seg_star   <= n_seg_star;
            r_wild       <= n_wild;
            r_out_len    <= n_out_len;
            r_err        <= n_err;
        end
    end

endmodule

// ===== design/nvd_back.sv =====
module nvd_back
    import nvd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_entry     i_entry,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic       r_valid;
    logic       r_phase;
    logic       r_kind;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic       r_last;

    logic load;
    logic emit_slash;

    // output register is free when empty or being taken this cycle
    assign load       = (!r_valid || i_out_ready) && !i_q_empty;
    assign emit_slash = i_entry.slash && !r_phase;
    assign o_pop      = load && !emit_slash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_phase <= emit_slash;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (emit_slash) begin
                r_kind   <= KIND_BYTE;
                r_byte   <= CH_SLASH;
                r_status <= ST_VALID;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= i_entry.kind;
                r_byte   <= i_entry.byte_val;
                r_status <= i_entry.status;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_byte;
    assign o_status    = r_status;
    assign o_last      = r_last;

endmodule

// ===== design/ref_name_validator_top.sv =====
// A result passes through the queue and then the output register before it is valid on
// the output; both are registered, so no result is combinational from its input.
// The block takes one name byte per cycle while the queue is not full; a byte that follows
// a separator yields two results, a '/' and the byte, absorbed by a four-entry queue.
// Reset (synchronous, active low) returns the name state, queue and output register
// to empty and the registers to their defaults; no clearing pass is needed.
module ref_name_validator_top
    import nvd_pkg::*;
#(
    parameter int NAME_MAX_LEN = NAME_MAX_LEN_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_name_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_kind,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_status,
    output logic                  o_last
);

    t_cfg   r_cfg;
    t_entry push_entry, head_entry;
    logic   push, pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.allow_one_level  <= 1'b1;
            r_cfg.pattern_mode     <= 1'b0;
            r_cfg.collapse_slashes <= 1'b1;
            r_cfg.max_length       <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALLOW_ONE_LEVEL:  r_cfg.allow_one_level  <= i_cfg_data[0];
                CFG_PATTERN_MODE:     r_cfg.pattern_mode     <= i_cfg_data[0];
                CFG_COLLAPSE_SLASHES: r_cfg.collapse_slashes <= i_cfg_data[0];
                CFG_MAX_LENGTH:       r_cfg.max_length       <= i_cfg_data;
                default:              r_cfg.max_length       <= r_cfg.max_length;
            endcase
        end
    end

    nvd_front #(
        .NAME_MAX_LEN (NAME_MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_name_byte (i_name_byte),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    nvd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (head_entry)
    );

    nvd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_entry     (head_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_out_byte  (o_out_byte),
        .o_status    (o_status),
        .o_last      (o_last)
    );

endmodule
